// ----- sv/canonical_kmer_extractor_macros.svh -----
// Assertion helpers for the checker file.
// Each expects clk and arst_n in the scope where it is used.
`ifndef CANONICAL_KMER_EXTRACTOR_MACROS_SVH
`define CANONICAL_KMER_EXTRACTOR_MACROS_SVH

// Same-cycle implication, checked out of reset only.
`define CKX_ASSERT_IMPL(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("canonical k-mer extractor: assertion failed");

// Next-cycle implication, checked out of reset only.
`define CKX_ASSERT_NEXT(name, ante, cons) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("canonical k-mer extractor: assertion failed");

`endif

// ----- sv/ckx_pkg.sv -----
package ckx_pkg;

	localparam int unsigned MAX_KMER_LENGTH_DEF = 31;
	localparam int unsigned CHAR_W              = 8;
	localparam int unsigned KMER_W              = 62;
	localparam int unsigned COUNT_W             = 5;
	localparam int unsigned APB_DATA_W          = 32;
	localparam int unsigned APB_ADDR_W          = 2;

	localparam logic [COUNT_W-1:0]    KLEN_RESET       = 5'd31;
	localparam logic [APB_ADDR_W-1:0] ADDR_KMER_LENGTH = 2'd0;

	localparam logic [CHAR_W-1:0] CHAR_A_UC = 8'h41;
	localparam logic [CHAR_W-1:0] CHAR_A_LC = 8'h61;
	localparam logic [CHAR_W-1:0] CHAR_C_UC = 8'h43;
	localparam logic [CHAR_W-1:0] CHAR_C_LC = 8'h63;
	localparam logic [CHAR_W-1:0] CHAR_G_UC = 8'h47;
	localparam logic [CHAR_W-1:0] CHAR_G_LC = 8'h67;
	localparam logic [CHAR_W-1:0] CHAR_T_UC = 8'h54;
	localparam logic [CHAR_W-1:0] CHAR_T_LC = 8'h74;

	typedef logic [1:0] base_code_t;

	localparam base_code_t BASE_A = 2'd0;
	localparam base_code_t BASE_C = 2'd1;
	localparam base_code_t BASE_G = 2'd2;
	localparam base_code_t BASE_T = 2'd3;

	typedef struct packed {
		logic       valid;
		base_code_t code;
	} base_dec_t;

	// Control that travels with the window from the first to the second stage.
	typedef struct packed {
		logic               valid;
		logic [COUNT_W-1:0] klen;
	} stage_ctl_t;

	function automatic base_dec_t decode_base(input logic [CHAR_W-1:0] ch);
		base_dec_t d;
		d.valid = 1'b1;
		d.code  = BASE_A;
		unique case (ch) inside
			CHAR_A_UC, CHAR_A_LC: d.code = BASE_A;
			CHAR_C_UC, CHAR_C_LC: d.code = BASE_C;
			CHAR_G_UC, CHAR_G_LC: d.code = BASE_G;
			CHAR_T_UC, CHAR_T_LC: d.code = BASE_T;
			default: begin
				d.valid = 1'b0;
				d.code  = BASE_A;
			end
		endcase
		return d;
	endfunction

endpackage

// ----- sv/ckx_base_if.sv -----
interface ckx_base_if import ckx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] base_char;
	logic              record_start;

	modport source (output valid, output base_char, output record_start, input ready);
	modport sink   (input valid, input base_char, input record_start, output ready);
endinterface

// ----- sv/ckx_kmer_if.sv -----
interface ckx_kmer_if import ckx_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [KMER_W-1:0] kmer_value;

	modport source (output valid, output kmer_value, input ready);
	modport sink   (input valid, input kmer_value, output ready);
endinterface

// ----- sv/ckx_apb_regs.sv -----
module ckx_apb_regs import ckx_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	output logic [COUNT_W-1:0]    kmer_length
);

	logic [COUNT_W-1:0] kmer_length_q;
	logic               wr_en;

	assign wr_en = psel && penable && pwrite && (paddr == ADDR_KMER_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kmer_length_q <= KLEN_RESET;
		end else if (wr_en) begin
			kmer_length_q <= pwdata[COUNT_W-1:0];
		end
	end

	// Single register: every read returns it.
	assign prdata      = APB_DATA_W'(kmer_length_q);
	assign pready      = 1'b1;
	assign kmer_length = kmer_length_q;

endmodule

// ----- sv/ckx_window.sv -----
module ckx_window import ckx_pkg::*; #(
	parameter int unsigned MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [COUNT_W-1:0]           kmer_length,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [CHAR_W-1:0]            base_char,
	input  logic                         record_start,
	input  logic                         can_take,
	output stage_ctl_t                   ctl_s1,
	output logic [2*MAX_KMER_LENGTH-1:0] window_s1
);

	localparam int unsigned WIN_W = 2 * MAX_KMER_LENGTH;
	localparam logic [COUNT_W-1:0] KMAX = COUNT_W'(MAX_KMER_LENGTH);

	logic [WIN_W-1:0]   window_q;
	logic [COUNT_W-1:0] count_q;
	logic [COUNT_W-1:0] klen;
	logic [WIN_W-1:0]   win_base;
	logic [COUNT_W-1:0] cnt_base;
	logic [WIN_W+1:0]   win_shift;
	logic [WIN_W-1:0]   keep_mask;
	logic [WIN_W-1:0]   win_next;
	logic [COUNT_W:0]   cnt_inc;
	logic [COUNT_W-1:0] count_next;
	logic               emit;
	logic               accept;
	logic               valid_s1;
	logic [COUNT_W-1:0] klen_s1;
	base_dec_t          dec;

	always_comb begin
		if (kmer_length == '0) begin
			klen = COUNT_W'(1);
		end else if (kmer_length > KMAX) begin
			klen = KMAX;
		end else begin
			klen = kmer_length;
		end
	end

	for (genvar j = 0; j < MAX_KMER_LENGTH; j++) begin : g_mask
		assign keep_mask[2*j +: 2] = {2{COUNT_W'(j) < klen}};
	end

	assign dec       = decode_base(base_char);
	assign win_base  = record_start ? '0 : window_q;
	assign cnt_base  = record_start ? '0 : count_q;
	assign win_shift = {win_base, dec.code};
	assign win_next  = win_shift[WIN_W-1:0] & keep_mask;
	assign cnt_inc   = {1'b0, cnt_base} + (COUNT_W+1)'(1);
	assign emit      = dec.valid && (cnt_inc >= {1'b0, klen});

	always_comb begin
		if (!dec.valid) begin
			count_next = '0;
		end else if (emit) begin
			count_next = klen - COUNT_W'(1);
		end else begin
			count_next = cnt_inc[COUNT_W-1:0];
		end
	end

	assign in_ready = !valid_s1 || can_take;
	assign accept   = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q  <= '0;
		end else if (accept) begin
			window_q <= dec.valid ? win_next : '0;
			count_q  <= count_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= emit;
		end else if (can_take) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && emit) begin
			klen_s1   <= klen;
			window_s1 <= win_next;
		end
	end

	assign ctl_s1.valid = valid_s1;
	assign ctl_s1.klen  = klen_s1;

endmodule

// ----- sv/ckx_canon.sv -----
module ckx_canon import ckx_pkg::*; #(
	parameter int unsigned MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stage_ctl_t                   ctl_s1,
	input  logic [2*MAX_KMER_LENGTH-1:0] window_s1,
	output logic                         can_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [KMER_W-1:0]            out_kmer
);

	localparam int unsigned WIN_W = 2 * MAX_KMER_LENGTH;
	localparam logic [COUNT_W-1:0] KMAX = COUNT_W'(MAX_KMER_LENGTH);

	logic [WIN_W-1:0]   keep_mask;
	logic [WIN_W-1:0]   comp;
	logic [WIN_W-1:0]   rev_full;
	logic [WIN_W-1:0]   rev_comp;
	logic [WIN_W-1:0]   canon;
	logic [COUNT_W-1:0] slack;
	logic               valid_s2;
	logic [KMER_W-1:0]  kmer_s2;

	for (genvar j = 0; j < MAX_KMER_LENGTH; j++) begin : g_rev
		assign keep_mask[2*j +: 2] = {2{COUNT_W'(j) < ctl_s1.klen}};
		// Base j lands in the mirrored slot of the full-width window.
		assign rev_full[2*(MAX_KMER_LENGTH-1-j) +: 2] = comp[2*j +: 2];
	end

	assign comp     = ~window_s1 & keep_mask;
	assign slack    = KMAX - ctl_s1.klen;
	assign rev_comp = rev_full >> {slack, 1'b0};
	assign canon    = (window_s1 < rev_comp) ? window_s1 : rev_comp;

	assign can_take = !valid_s2 || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (can_take) begin
			valid_s2 <= ctl_s1.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (can_take && ctl_s1.valid) begin
			kmer_s2 <= KMER_W'(canon);
		end
	end

	assign out_valid = valid_s2;
	assign out_kmer  = kmer_s2;

endmodule

// ----- sv/canonical_kmer_extractor.sv -----
// Canonical k-mer extractor. Takes one ASCII base per transaction on the bases
// channel (A, C, G, T in either case; record_start clears the window first)
// and, from the kmer_length-th valid base in a row on, returns for that base
// and each further one the smaller of the current k-mer and its reverse complement,
// two bits per base, on the kmers channel. Any other character clears the
// window and the run count and gives no result. The block takes one base
// every clock cycle while the kmers channel is not backed up; a result passes
// the window stage register and then the reverse complement and compare stage
// register before it is offered, and both stages hold under back-pressure
// without loss. kmer_length lives at APB address 0, keeps and reads back the
// low COUNT_W bits of a write, and acts as 1 when they are 0 and as MAX_KMER_LENGTH
// when they are higher; change it only while no base is in flight.
module canonical_kmer_extractor import ckx_pkg::*; #(
	parameter int unsigned MAX_KMER_LENGTH = MAX_KMER_LENGTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	ckx_base_if.sink              bases,
	ckx_kmer_if.source            kmers
);

	logic [COUNT_W-1:0]           kmer_length;
	logic                         can_take;
	stage_ctl_t                   ctl_s1;
	logic [2*MAX_KMER_LENGTH-1:0] window_s1;

	// Configuration register file.
	ckx_apb_regs u_regs (
		.clk         (clk),
		.arst_n      (arst_n),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready),
		.kmer_length (kmer_length)
	);

	// Decode the base, advance the rolling window and decide whether to emit.
	ckx_window #(
		.MAX_KMER_LENGTH (MAX_KMER_LENGTH)
	) u_window (
		.clk          (clk),
		.arst_n       (arst_n),
		.kmer_length  (kmer_length),
		.in_valid     (bases.valid),
		.in_ready     (bases.ready),
		.base_char    (bases.base_char),
		.record_start (bases.record_start),
		.can_take     (can_take),
		.ctl_s1       (ctl_s1),
		.window_s1    (window_s1)
	);

	// Form the reverse complement, keep the smaller, hold it for the sink.
	ckx_canon #(
		.MAX_KMER_LENGTH (MAX_KMER_LENGTH)
	) u_canon (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl_s1    (ctl_s1),
		.window_s1 (window_s1),
		.can_take  (can_take),
		.out_valid (kmers.valid),
		.out_ready (kmers.ready),
		.out_kmer  (kmers.kmer_value)
	);

endmodule

// ----- sv/ckx_checker.sv -----
`include "canonical_kmer_extractor_macros.svh"

module ckx_checker import ckx_pkg::*; (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  in_valid,
	input logic                  in_ready,
	input logic                  out_valid,
	input logic                  out_ready,
	input logic [KMER_W-1:0]     out_kmer,
	input logic                  psel,
	input logic                  penable,
	input logic                  pwrite,
	input logic [APB_ADDR_W-1:0] paddr,
	input logic [APB_DATA_W-1:0] pwdata,
	input logic [APB_DATA_W-1:0] prdata
);

	logic cfg_wr;

	assign cfg_wr = psel && penable && pwrite && (paddr == ADDR_KMER_LENGTH);

	// A stalled result holds.
	`CKX_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_kmer))

	// A fresh result traces back to an accepted base.
	`CKX_ASSERT_IMPL(a_out_origin, $rose(out_valid), $past(in_valid && in_ready, 2))

	// Input stalls only when the result register is full and blocked.
	`CKX_ASSERT_IMPL(a_in_stall, !in_ready, out_valid && !out_ready)

	// The length register reads back the low COUNT_W bits of what was written.
	`CKX_ASSERT_NEXT(a_cfg_readback, cfg_wr, prdata[COUNT_W-1:0] == $past(pwdata[COUNT_W-1:0]))

endmodule

bind canonical_kmer_extractor ckx_checker u_ckx_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bases.valid),
	.in_ready  (bases.ready),
	.out_valid (kmers.valid),
	.out_ready (kmers.ready),
	.out_kmer  (kmers.kmer_value),
	.psel      (psel),
	.penable   (penable),
	.pwrite    (pwrite),
	.paddr     (paddr),
	.pwdata    (pwdata),
	.prdata    (prdata)
);
